### sv/brf_pkg.sv
// Shared types, constants and helpers for the chunked byte ring FIFO.
// No dependencies; the controller, result queue and top level import this package.
package brf_pkg;

    localparam int BRF_DEPTH  = 4096;
    localparam int BRF_AW     = $clog2(BRF_DEPTH);
    localparam int CAP_W      = BRF_AW + 1;
    localparam int MAX_CHUNK  = 64;
    localparam int LEN_W      = 7;
    localparam int BYTE_W     = 8;
    // Output queue depth; must be a power of two so the pointers wrap by themselves.
    localparam int OUTQ_DEPTH = 4;
    localparam int QPTR_W     = $clog2(OUTQ_DEPTH);
    localparam int QCNT_W     = $clog2(OUTQ_DEPTH + 1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NODATA  = 2'd2,
        ST_STRAY   = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   rbyte;
        logic                last;
    } brf_result_t;

    typedef struct packed {
        logic        valid;
        brf_result_t res;
    } brf_push_t;

    typedef struct packed {
        logic              we;
        logic [BRF_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [BRF_AW-1:0] raddr;
    } brf_ram_req_t;

    // Advance a ring index, wrapping at the capacity in use.
    function automatic logic [BRF_AW-1:0] brf_bump(input logic [BRF_AW-1:0] idx,
                                                   input logic [CAP_W-1:0]  cap);
        logic [CAP_W-1:0] n;
        n = {1'b0, idx} + CAP_W'(1);
        return (n >= cap) ? '0 : n[BRF_AW-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] brf_len_clamp(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] v;
        v = raw;
        if (raw == '0)
            v = LEN_W'(1);
        else if (raw > LEN_W'(MAX_CHUNK))
            v = LEN_W'(MAX_CHUNK);
        return v;
    endfunction

    function automatic logic [CAP_W-1:0] brf_cap_clamp(input logic [CAP_W-1:0] raw);
        logic [CAP_W-1:0] v;
        v = raw;
        if (raw == '0)
            v = CAP_W'(1);
        else if (raw > CAP_W'(BRF_DEPTH))
            v = CAP_W'(BRF_DEPTH);
        return v;
    endfunction

endpackage

### sv/brf_ram.sv
// Generic simple dual-port synchronous RAM with registered read data.
// Standalone; one write port and one read port.
module brf_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/brf_outq.sv
// Small result queue that decouples the controller from the output stream.
// Depends on brf_pkg for the result type and queue sizing.
module brf_outq import brf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  brf_push_t         push,
    output logic [QCNT_W-1:0] count,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // read_byte[7:0]
    output logic [1:0]        m_axis_tuser,   // status[1:0]
    output logic              m_axis_tlast    // last
);

    brf_result_t       entry_reg [OUTQ_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign pop = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push.valid)
        begin
            tail_next = tail_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            head_next = head_reg + QPTR_W'(1);
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[tail_reg] <= push.res;
        end
    end

    assign count         = count_reg;
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = entry_reg[head_reg].rbyte;
    assign m_axis_tuser  = entry_reg[head_reg].status;
    assign m_axis_tlast  = entry_reg[head_reg].last;

endmodule

### sv/brf_ctrl.sv
// Controller: ring indices, fill count, chunk tracking and read sequencing.
// Depends on brf_pkg; drives the byte store RAM and pushes into the result queue.
module brf_ctrl import brf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_cmd,
    input  logic              in_first,
    input  logic [LEN_W-1:0]  in_length,
    input  logic [BYTE_W-1:0] in_data,
    output brf_ram_req_t      ram_req,
    input  logic [BYTE_W-1:0] ram_rdata,
    input  logic [QCNT_W-1:0] q_count,
    output brf_push_t         push
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  capacity_reg, capacity_next;
    logic [BRF_AW-1:0] write_index_reg, write_index_next;
    logic [BRF_AW-1:0] read_index_reg, read_index_next;
    logic [BRF_AW-1:0] commit_index_reg, commit_index_next;
    logic [CAP_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  chunk_rem_reg, chunk_rem_next;
    logic              chunk_acc_reg, chunk_acc_next;
    logic [LEN_W-1:0]  chunk_len_reg, chunk_len_next;
    logic [LEN_W-1:0]  rd_left_reg, rd_left_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;

    logic              accept;
    logic [LEN_W-1:0]  len_eff;
    logic [CAP_W-1:0]  len_wide;
    logic [QCNT_W:0]   q_load;
    logic              issue_ok;
    logic [BRF_AW-1:0] w_idx;
    logic [LEN_W-1:0]  w_rem;
    logic              w_acc;
    logic [LEN_W-1:0]  w_clen;
    logic [BRF_AW-1:0] w_idx_bumped;

    assign len_eff  = brf_len_clamp(in_length);
    assign len_wide = CAP_W'(len_eff);
    assign q_load   = {1'b0, q_count} + (QCNT_W + 1)'(pend_reg);
    assign issue_ok = (state_reg == S_READ) && (q_load < (QCNT_W + 1)'(OUTQ_DEPTH));
    assign in_ready = (state_reg == S_IDLE) && !pend_reg
                      && (q_count < QCNT_W'(OUTQ_DEPTH));
    assign accept   = in_valid && in_ready;
    assign w_idx_bumped = brf_bump(w_idx, capacity_reg);

    always_comb
    begin
        state_next        = state_reg;
        capacity_next     = capacity_reg;
        write_index_next  = write_index_reg;
        read_index_next   = read_index_reg;
        commit_index_next = commit_index_reg;
        fill_next         = fill_reg;
        chunk_rem_next    = chunk_rem_reg;
        chunk_acc_next    = chunk_acc_reg;
        chunk_len_next    = chunk_len_reg;
        rd_left_next      = rd_left_reg;
        pend_next         = 1'b0;
        pend_last_next    = pend_last_reg;
        ram_req           = '0;
        push              = '0;

        // A new chunk restarts from the committed end, dropping any unfinished one.
        if (in_first)
        begin
            w_idx  = commit_index_reg;
            w_rem  = len_eff;
            w_acc  = ((capacity_reg - fill_reg) >= len_wide);
            w_clen = len_eff;
        end
        else
        begin
            w_idx  = write_index_reg;
            w_rem  = chunk_rem_reg;
            w_acc  = chunk_acc_reg;
            w_clen = chunk_len_reg;
        end

        // Read data returns in the cycle after its address was issued.
        if (pend_reg)
        begin
            push.valid      = 1'b1;
            push.res.status = ST_OK;
            push.res.rbyte  = ram_rdata;
            push.res.last   = pend_last_reg;
        end

        case (state_reg)
            S_READ:
            begin
                if (issue_ok)
                begin
                    ram_req.re      = 1'b1;
                    ram_req.raddr   = read_index_reg;
                    read_index_next = brf_bump(read_index_reg, capacity_reg);
                    rd_left_next    = rd_left_reg - LEN_W'(1);
                    pend_next       = 1'b1;
                    pend_last_next  = (rd_left_reg == LEN_W'(1));
                    if (rd_left_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    push.valid    = 1'b1;
                    push.res.last = 1'b1;
                    if (in_cmd == CMD_READ)
                    begin
                        if (fill_reg < len_wide)
                        begin
                            push.res.status = ST_NODATA;
                        end
                        else
                        begin
                            // The burst itself supplies the results.
                            push.valid   = 1'b0;
                            state_next   = S_READ;
                            rd_left_next = len_eff;
                            fill_next    = fill_reg - len_wide;
                        end
                    end
                    else if (!in_first && (chunk_rem_reg == '0))
                    begin
                        push.res.status = ST_STRAY;
                    end
                    else
                    begin
                        write_index_next = w_idx;
                        chunk_rem_next   = w_rem - LEN_W'(1);
                        chunk_acc_next   = w_acc;
                        chunk_len_next   = w_clen;
                        if (!w_acc)
                        begin
                            push.res.status = ST_NOSPACE;
                        end
                        else
                        begin
                            push.res.status  = ST_OK;
                            ram_req.we       = 1'b1;
                            ram_req.waddr    = w_idx;
                            ram_req.wdata    = in_data;
                            write_index_next = w_idx_bumped;
                            if (w_rem == LEN_W'(1))
                            begin
                                fill_next         = fill_reg + CAP_W'(w_clen);
                                chunk_acc_next    = 1'b0;
                                commit_index_next = w_idx_bumped;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A capacity write empties the FIFO.
        if (cfg_we)
        begin
            capacity_next     = brf_cap_clamp(cfg_wdata);
            write_index_next  = '0;
            read_index_next   = '0;
            commit_index_next = '0;
            fill_next         = '0;
            chunk_rem_next    = '0;
            chunk_acc_next    = 1'b0;
            chunk_len_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            capacity_reg     <= CAP_W'(BRF_DEPTH);
            write_index_reg  <= '0;
            read_index_reg   <= '0;
            commit_index_reg <= '0;
            fill_reg         <= '0;
            chunk_rem_reg    <= '0;
            chunk_acc_reg    <= 1'b0;
            chunk_len_reg    <= '0;
            rd_left_reg      <= '0;
            pend_reg         <= 1'b0;
            pend_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            capacity_reg     <= capacity_next;
            write_index_reg  <= write_index_next;
            read_index_reg   <= read_index_next;
            commit_index_reg <= commit_index_next;
            fill_reg         <= fill_next;
            chunk_rem_reg    <= chunk_rem_next;
            chunk_acc_reg    <= chunk_acc_next;
            chunk_len_reg    <= chunk_len_next;
            rd_left_reg      <= rd_left_next;
            pend_reg         <= pend_next;
            pend_last_reg    <= pend_last_next;
        end
    end

endmodule

### sv/byte_ring_fifo_chunked_top.sv
// Top level of the chunked byte ring FIFO: controller, byte store and result queue.
// Depends on brf_pkg, brf_ram, brf_outq and brf_ctrl.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata, tuser
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata, tuser, tlast
//  cfg       in         cfg_we (no wait)               cfg_wdata (capacity)
//
// A write byte gives one result; write bytes can follow back to back while the queue has room.
// A read of length L issues one store address per cycle while the queue has room, and it
// holds off input until its last byte is pushed: the store has one registered read port.
// Reset empties the FIFO and sets the capacity to the full store; the store needs no clearing.
// Output stalls fill a four-beat result queue, which then holds off input and read issue.
module byte_ring_fifo_chunked_top import brf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // length[6:0], data_byte[14:7], zero[15]
    input  logic [1:0]  s_axis_tuser,   // cmd[0], first_of_chunk[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // read_byte[7:0]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    brf_ram_req_t      ram_req;
    logic [BYTE_W-1:0] ram_rdata;
    logic [QCNT_W-1:0] q_count;
    brf_push_t         push;

    brf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser[0]),
        .in_first  (s_axis_tuser[1]),
        .in_length (s_axis_tdata[6:0]),
        .in_data   (s_axis_tdata[14:7]),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .q_count   (q_count),
        .push      (push)
    );

    brf_ram #(
        .DEPTH (BRF_DEPTH),
        .WIDTH (BYTE_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    brf_outq u_outq (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .count         (q_count),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The result queue must never be pushed while full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (q_count < QCNT_W'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    // Every store read returns its byte as a result in the next cycle.
    a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.re |=> (push.valid && (push.res.status == ST_OK)))
        else $error("store read data not pushed");

    // No input beat is taken while a read burst is using the store.
    a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.re |-> !(s_axis_tvalid && s_axis_tready))
        else $error("input accepted during read burst");

    // Writes and reads of the store never share a cycle.
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("store written and read in the same cycle");

endmodule
